### rtl/core/cpm_pkg.sv
// Package for the per-process CPU share monitor.
// Holds field widths, the percent scale and the divider request/response types.
// No dependencies.
package cpm_pkg;

  localparam int ID_W      = 8;
  localparam int TICK_W    = 32;
  localparam int PCT_W     = 7;
  localparam int QUOT_BITS = 7;
  // Product of a tick count and the percent scale fits in this many bits.
  localparam int PROD_W    = TICK_W + QUOT_BITS;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] part;
    logic [TICK_W-1:0] whole;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/cpm_if.sv
// Valid/ready channel interfaces for the CPU share monitor.
// Depends on cpm_pkg for the field widths.
interface cpm_in_if;
  import cpm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   proc_id;
  logic [TICK_W-1:0] tick_total;
  logic [TICK_W-1:0] now_ticks;
  logic              first_rec;
  logic              last_rec;

  modport source (output valid, proc_id, tick_total, now_ticks, first_rec, last_rec,
                  input ready);
  modport sink (input valid, proc_id, tick_total, now_ticks, first_rec, last_rec,
                output ready);
endinterface

interface cpm_out_if;
  import cpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] share_pct;
  logic             share_reported;
  logic [PCT_W-1:0] total_pct;
  logic             total_valid;
  logic             baseline_only;

  modport source (output valid, share_pct, share_reported, total_pct, total_valid,
                  baseline_only, input ready);
  modport sink (input valid, share_pct, share_reported, total_pct, total_valid,
                baseline_only, output ready);
endinterface

### rtl/core/per_process_cpu_share_monitor.sv
// Top level of the per-process CPU share monitor.
// Depends on cpm_pkg, cpm_if (channels), cpm_ram (counter table) and cpm_divider.
//
//  Channel  Direction  Handshake      Payload
//  in_ch    sink       valid/ready    proc_id, tick_total, now_ticks, first_rec, last_rec
//  out_ch   source     valid/ready    share_pct, share_reported, total_pct, total_valid,
//                                     baseline_only
//
// One request is processed at a time. A request with a share waits for the divider,
// and the last request of a sample also waits for the division of the total; the
// bit-serial divider produces one quotient bit per cycle.
// Reset (synchronous, rst_n low) clears the masks and timing state; the counter
// table needs no clearing. A stalled output holds its register while the next
// request is already accepted and processed.
module per_process_cpu_share_monitor #(
  parameter int TABLE_SIZE = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  cpm_in_if.sink       in_ch,
  cpm_out_if.source    out_ch
);
  import cpm_pkg::*;

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SHARE, S_TOT_START, S_TOTAL, S_OUT
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    idx_r;
  logic                tracked_r;
  logic [TICK_W-1:0]   ticks_r;
  logic                last_r;
  logic [TICK_W-1:0]   interval_r;
  logic [TICK_W-1:0]   last_time_r;
  logic [TICK_W-1:0]   busy_r;
  logic [TABLE_SIZE-1:0] seen_r;
  logic [TABLE_SIZE-1:0] baseline_r;
  logic [PCT_W-1:0]    share_r;
  logic                reported_r;
  logic [PCT_W-1:0]    total_r;
  logic                tvalid_r;
  logic                base_r;

  logic                out_vld_r;
  logic [PCT_W-1:0]    out_share_r;
  logic                out_reported_r;
  logic [PCT_W-1:0]    out_total_r;
  logic                out_tvalid_r;
  logic                out_base_r;

  logic                in_fire;
  logic                out_free;
  logic [TICK_W-1:0]   ram_rdata;
  logic                ram_we;
  logic [TABLE_SIZE-1:0] id_bit;
  logic                has_base;
  logic [TICK_W-1:0]   d_raw;
  logic [TICK_W-1:0]   d_clamp;
  logic [TICK_W-1:0]   room;
  logic [TICK_W-1:0]   busy_nxt;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;

  // Previous counter per identifier, read as the request is accepted.
  assign ram_we = (state_r == S_READ) && tracked_r;

  cpm_ram #(
    .WIDTH (TICK_W),
    .DEPTH (TABLE_SIZE)
  ) u_counter_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ticks_r),
    .raddr (in_ch.proc_id[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Wrapped difference, clamped to the interval, and the saturating busy sum.
  assign id_bit   = {{(TABLE_SIZE-1){1'b0}}, 1'b1} << idx_r;
  assign has_base = (baseline_r & id_bit) != '0;
  assign d_raw    = ticks_r - ram_rdata;
  assign d_clamp  = (d_raw > interval_r) ? interval_r : d_raw;
  assign room     = interval_r - busy_r;
  assign busy_nxt = (d_clamp > room) ? interval_r : busy_r + d_clamp;

  // Divider requests: the share from the read state, the total later.
  always_comb begin
    div_req.start = ((state_r == S_READ) && (interval_r != '0) && tracked_r && has_base)
                    || (state_r == S_TOT_START);
    div_req.part  = (state_r == S_READ) ? d_clamp : busy_r;
    div_req.whole = interval_r;
  end

  cpm_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // Request sequencer, sample state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_vld_r   <= 1'b0;
      interval_r  <= '0;
      last_time_r <= '0;
      busy_r      <= '0;
      seen_r      <= '0;
      baseline_r  <= '0;
    end else begin
      // The output register empties unless the output state refills it.
      if (out_vld_r && out_ch.ready && (state_r != S_OUT)) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            idx_r      <= in_ch.proc_id[IDX_W-1:0];
            tracked_r  <= 32'(in_ch.proc_id) < TABLE_SIZE;
            ticks_r    <= in_ch.tick_total;
            last_r     <= in_ch.last_rec;
            share_r    <= '0;
            reported_r <= 1'b0;
            total_r    <= '0;
            tvalid_r   <= 1'b0;
            base_r     <= 1'b0;
            if (in_ch.first_rec) begin
              interval_r  <= in_ch.now_ticks - last_time_r;
              last_time_r <= in_ch.now_ticks;
              busy_r      <= '0;
              seen_r      <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (interval_r == '0) begin
            // Zero interval: only record baselines.
            base_r <= 1'b1;
            if (tracked_r) begin
              baseline_r <= baseline_r | id_bit;
            end
            state_r <= S_OUT;
          end else begin
            if (tracked_r) begin
              seen_r <= seen_r | id_bit;
            end
            if (tracked_r && has_base) begin
              busy_r     <= busy_nxt;
              reported_r <= 1'b1;
              state_r    <= S_SHARE;
            end else if (last_r) begin
              state_r <= S_TOT_START;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_SHARE: begin
          if (div_rsp.done) begin
            share_r <= div_rsp.quot;
            state_r <= last_r ? S_TOT_START : S_OUT;
          end
        end
        S_TOT_START: begin
          // The sample closes: identifiers seen now become the baseline set.
          baseline_r <= seen_r;
          state_r    <= S_TOTAL;
        end
        S_TOTAL: begin
          if (div_rsp.done) begin
            total_r  <= div_rsp.quot;
            tvalid_r <= 1'b1;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_vld_r      <= 1'b1;
            out_share_r    <= share_r;
            out_reported_r <= reported_r;
            out_total_r    <= total_r;
            out_tvalid_r   <= tvalid_r;
            out_base_r     <= base_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.share_pct      = out_share_r;
  assign out_ch.share_reported = out_reported_r;
  assign out_ch.total_pct      = out_total_r;
  assign out_ch.total_valid    = out_tvalid_r;
  assign out_ch.baseline_only  = out_base_r;

  // A baseline-only result never carries a share.
  a_no_share_on_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.share_reported && out_ch.baseline_only))
    else $error("share reported on a zero-interval sample");

  // A total is only produced for the last request of a sample.
  a_total_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && tvalid_r) |-> last_r)
    else $error("total produced on a request that is not last");

  // The saturating busy sum never exceeds the interval.
  a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r <= interval_r)
    else $error("busy sum exceeds interval");

  // An accepted request goes straight to the table read.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_READ))
    else $error("accepted request did not enter the read state");

endmodule

### rtl/core/cpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/cpm_divider.sv
// Restoring divider for percentages: quot = (part * 100) / whole, part <= whole.
// One quotient bit per cycle, shared by the share and total requests. Depends on cpm_pkg.
module cpm_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  cpm_pkg::div_req_t  div_req,
  output cpm_pkg::div_rsp_t  div_rsp
);
  import cpm_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  localparam int CNT_W = $clog2(QUOT_BITS);

  dstate_t              state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PROD_W-1:0]    rem_r;
  logic [PROD_W-1:0]    dsr_r;
  logic [QUOT_BITS-1:0] quot_r;
  logic                 done_r;
  logic                 fits;

  assign fits = rem_r >= dsr_r;

  // Sequencer: load the scaled dividend, then one trial subtraction per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (div_req.start) begin
            rem_r   <= PROD_W'(div_req.part) * PROD_W'(PCT_SCALE);
            dsr_r   <= {1'b0, div_req.whole, {(QUOT_BITS-1){1'b0}}};
            quot_r  <= '0;
            cnt_r   <= CNT_W'(QUOT_BITS-1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) begin
            rem_r <= rem_r - dsr_r;
          end
          quot_r <= {quot_r[QUOT_BITS-2:0], fits};
          dsr_r  <= dsr_r >> 1;
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quot = quot_r;

endmodule
